### sv/assert_macros.svh
// assertion macros shared by the rail fence encrypt unit
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked on every rising clock edge, muted during reset
`define RFE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rail fence check failed");
// condition that must never be seen
`define RFE_NEVER(label, clk, rst_n, expr) \
    `RFE_ASSERT(label, clk, rst_n, !(expr))
`else
`define RFE_ASSERT(label, clk, rst_n, prop)
`define RFE_NEVER(label, clk, rst_n, expr)
`endif
`endif

### sv/rfe_pkg.sv
// shared types and constants of the rail fence encrypt unit
// no dependencies; imported by every module of the block
package rfe_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 4;

    localparam logic [BYTE_W-1:0] SPACE_CODE       = 8'h20;
    localparam logic [CFG_W-1:0]  RAIL_COUNT_RESET = 4'd3;
    localparam int                MIN_RAILS        = 2;

    // status of the read scheduler toward the datapath
    typedef struct packed {
        logic busy;   // walking the zigzag of one message
        logic issue;  // a memory read is launched this cycle
        logic last;   // the launched read is the final byte of the message
    } t_sched_stat;

endpackage

### sv/rfe_store.sv
// message buffer: one write port, one read port with registered data
// depends on rfe_pkg for the byte width
module rfe_store #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [rfe_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [rfe_pkg::BYTE_W-1:0] o_rd_data
);
    import rfe_pkg::*;

    logic [BYTE_W-1:0] r_mem [MAX_LEN];
    logic [BYTE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while no read is launched
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/rfe_sched.sv
// read scheduler: walks rails and zigzag periods, one candidate position a cycle while i_adv is high
// depends on rfe_pkg for the status struct; drives the read port of rfe_store
`include "assert_macros.svh"
module rfe_sched #(
    parameter int AW = 6,
    parameter int CW = 7,
    parameter int RW = 4,
    parameter int PW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CW-1:0]        i_count,
    input  logic [RW-1:0]        i_rails,
    input  logic                 i_adv,
    output logic [AW-1:0]        o_rd_addr,
    output rfe_pkg::t_sched_stat o_stat
);
    import rfe_pkg::*;

    logic          r_busy;
    logic [RW-1:0] r_rail;
    logic [RW-1:0] r_last_rail;
    logic [PW-1:0] r_base;
    logic [PW-1:0] r_period;
    logic [PW-1:0] r_pmr;      // period minus current rail
    logic          r_phase;    // second position of a middle rail
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_k;

    logic [PW-1:0] pos;
    logic [PW-1:0] next_base;
    logic          hit;
    logic          mid_rail;
    logic          issue;

    // candidate position and its bound check
    always_comb begin
        pos       = r_phase ? (r_base + r_pmr) : (r_base + PW'(r_rail));
        hit       = pos < PW'(r_n);
        next_base = r_base + r_period;
        mid_rail  = (r_rail != '0) && (r_rail != r_last_rail);
        issue     = r_busy && i_adv && hit;
    end

    assign o_rd_addr    = pos[AW-1:0];
    assign o_stat.busy  = r_busy;
    assign o_stat.issue = issue;
    assign o_stat.last  = (r_k == (r_n - CW'(1)));

    // zigzag walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy      <= 1'b1;
            r_rail      <= '0;
            r_last_rail <= i_rails - RW'(1);
            r_base      <= '0;
            r_period    <= PW'({i_rails - RW'(1), 1'b0});
            r_pmr       <= PW'({i_rails - RW'(1), 1'b0});
            r_phase     <= 1'b0;
            r_n         <= i_count;
            r_k         <= '0;
        end else if (r_busy && i_adv) begin
            if (issue) begin
                r_k <= r_k + CW'(1);
            end
            if (mid_rail && !r_phase) begin
                r_phase <= 1'b1;
            end else begin
                r_phase <= 1'b0;
                if (next_base >= PW'(r_n)) begin
                    r_base <= '0;
                    if (r_rail == r_last_rail) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_rail <= r_rail + RW'(1);
                        r_pmr  <= r_pmr - PW'(1);
                    end
                end else begin
                    r_base <= next_base;
                end
            end
        end
    end

    `RFE_ASSERT(a_rail_in_range, i_clk, i_rst_n, r_busy |-> (r_rail <= r_last_rail))
    `RFE_ASSERT(a_issue_below_count, i_clk, i_rst_n, issue |-> (r_k < r_n))
    `RFE_ASSERT(a_all_read_at_end, i_clk, i_rst_n, $fell(r_busy) |-> (r_k == r_n))

endmodule

### sv/rail_fence_encrypt_unit.sv
// rail fence encrypt unit: buffers a message, then streams it out in rail order
// the last input beat starts the zigzag walk; each result byte passes the buffer read register
// and the output register; load takes one beat a cycle while no walk runs; emission visits one zigzag
// position a cycle unless the output stalls, via the single buffer read port, 2*(rails-1) per period
// no input is taken while the zigzag walk runs; results drain through a 2-stage path
// reset (synchronous, active low) clears control and sets rail_count to 3; buffer is not cleared
`include "assert_macros.svh"
module rail_fence_encrypt_unit #(
    parameter int MAX_LEN   = 64,
    parameter int MAX_RAILS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [rfe_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
    input  logic                       s_axis_tlast,   // in_last
    // result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [rfe_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast,   // out_last
    output logic                       m_axis_tuser,   // [0] overflowed
    // rail count register
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rfe_pkg::CFG_W-1:0]  i_cfg_data
);
    import rfe_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int RW = $clog2(MAX_RAILS + 1);
    localparam int PW = $clog2(MAX_LEN + 2 * MAX_RAILS + 1);
    localparam int EW = (RW > CFG_W) ? RW : CFG_W;

    logic [CFG_W-1:0]  r_rail_count;
    logic [CW-1:0]     r_count;
    logic              r_ovf;
    logic              r_emit_ovf;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic              r_rd_ovf;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_ovf;

    logic              s_beat;
    logic              keep;
    logic              full;
    logic              wr_en;
    logic              ovf_now;
    logic [CW-1:0]     n_count;
    logic              start;
    logic [EW-1:0]     rc_ext;
    logic [RW-1:0]     rails;
    logic              move1;
    logic              adv;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    t_sched_stat       stat;

    // configuration, to be written only while idle: the user is bound, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail_count <= RAIL_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_rail_count <= i_cfg_data;
        end
    end

    // clamp rail count into the supported range
    always_comb begin
        rc_ext = EW'(r_rail_count);
        if (rc_ext < EW'(MIN_RAILS)) begin
            rails = RW'(MIN_RAILS);
        end else if (rc_ext > EW'(MAX_RAILS)) begin
            rails = RW'(MAX_RAILS);
        end else begin
            rails = rc_ext[RW-1:0];
        end
    end

    // load side
    assign s_axis_tready = !stat.busy;

    always_comb begin
        s_beat  = s_axis_tvalid && s_axis_tready;
        keep    = s_axis_tdata != SPACE_CODE;
        full    = r_count >= CW'(MAX_LEN);
        wr_en   = s_beat && keep && !full;
        ovf_now = r_ovf || (s_beat && keep && full);
        n_count = r_count + CW'(wr_en);
        start   = s_beat && s_axis_tlast && (n_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (s_beat) begin
            if (s_axis_tlast) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_ovf   <= ovf_now;
            end
        end
    end

    // overflow flag of the message being emitted
    always_ff @(posedge i_clk) begin
        if (s_beat && s_axis_tlast) begin
            r_emit_ovf <= ovf_now;
        end
    end

    rfe_store #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (stat.issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // read stage may launch when it will be free next cycle
    assign move1 = r_rd_vld && (!r_out_vld || m_axis_tready);
    assign adv   = !r_rd_vld || !r_out_vld || m_axis_tready;

    rfe_sched #(
        .AW (AW),
        .CW (CW),
        .RW (RW),
        .PW (PW)
    ) u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_count   (n_count),
        .i_rails   (rails),
        .i_adv     (adv),
        .o_rd_addr (rd_addr),
        .o_stat    (stat)
    );

    // tags that travel beside the memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (stat.issue) begin
            r_rd_vld <= 1'b1;
        end else if (move1) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.issue) begin
            r_rd_last <= stat.last;
            r_rd_ovf  <= r_emit_ovf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move1) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r_out_byte <= rd_data;
            r_out_last <= r_rd_last;
            r_out_ovf  <= r_rd_ovf;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

    `RFE_NEVER(a_no_load_while_walking, i_clk, i_rst_n, s_beat && stat.busy)
    `RFE_ASSERT(a_issue_has_room, i_clk, i_rst_n, stat.issue |-> adv)
    `RFE_ASSERT(a_count_bounded, i_clk, i_rst_n, r_count <= CW'(MAX_LEN))
    `RFE_ASSERT(a_start_begins_walk, i_clk, i_rst_n, start |=> stat.busy)

endmodule
